// File: design/dmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dmq_pkg;

    localparam int DEF_MAX_WIDTH       = 1024;
    localparam int DEF_ERROR_FRAC_BITS = 24;

    localparam logic [2:0] MODE_ROUND    = 3'd0;
    localparam logic [2:0] MODE_BAYER8   = 3'd1;
    localparam logic [2:0] MODE_HALF4    = 3'd2;
    localparam logic [2:0] MODE_FLOYD    = 3'd3;
    localparam logic [2:0] MODE_JJN      = 3'd4;
    localparam logic [2:0] MODE_SIERRA   = 3'd5;
    localparam logic [2:0] MODE_ATKINSON = 3'd6;

    localparam logic [1:0] REG_QUANT_BITS   = 2'd0;
    localparam logic [1:0] REG_DITHER_MODE  = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    localparam logic [3:0]  RST_QUANT_BITS   = 4'd1;
    localparam logic [2:0]  RST_DITHER_MODE  = MODE_ROUND;
    localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd1;

    typedef struct packed {
        logic signed [2:0] dx;
        logic [1:0]        dy;
        logic [2:0]        w;
    } t_tap;

    localparam logic [5:0] BAYER8 [64] = '{
        6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
        6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
        6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
        6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
        6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
        6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
        6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
        6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21};

    localparam logic [4:0] HALF4 [16] = '{
        5'd7,  5'd13, 5'd11, 5'd4,
        5'd12, 5'd16, 5'd14, 5'd8,
        5'd10, 5'd15, 5'd6,  5'd2,
        5'd5,  5'd9,  5'd3,  5'd1};

    function automatic t_tap mk_tap(input int dx, input int dy, input int w);
        t_tap t;
        t.dx = 3'(dx);
        t.dy = 2'(dy);
        t.w  = 3'(w);
        return t;
    endfunction

    function automatic t_tap tap_of(input logic [2:0] mode, input logic [3:0] idx);
        t_tap t;
        t = mk_tap(0, 0, 0);
        case (mode)
            MODE_FLOYD: begin
                case (idx)
                    4'd0: t = mk_tap(1, 0, 7);
                    4'd1: t = mk_tap(-1, 1, 3);
                    4'd2: t = mk_tap(0, 1, 5);
                    4'd3: t = mk_tap(1, 1, 1);
                    default: t = mk_tap(0, 0, 0);
                endcase
            end
            MODE_JJN: begin
                case (idx)
                    4'd0:  t = mk_tap(1, 0, 7);
                    4'd1:  t = mk_tap(2, 0, 5);
                    4'd2:  t = mk_tap(-2, 1, 3);
                    4'd3:  t = mk_tap(-1, 1, 5);
                    4'd4:  t = mk_tap(0, 1, 7);
                    4'd5:  t = mk_tap(1, 1, 5);
                    4'd6:  t = mk_tap(2, 1, 3);
                    4'd7:  t = mk_tap(-2, 2, 1);
                    4'd8:  t = mk_tap(-1, 2, 3);
                    4'd9:  t = mk_tap(0, 2, 5);
                    4'd10: t = mk_tap(1, 2, 3);
                    4'd11: t = mk_tap(2, 2, 1);
                    default: t = mk_tap(0, 0, 0);
                endcase
            end
            MODE_SIERRA: begin
                case (idx)
                    4'd0: t = mk_tap(1, 0, 5);
                    4'd1: t = mk_tap(2, 0, 3);
                    4'd2: t = mk_tap(-2, 1, 2);
                    4'd3: t = mk_tap(-1, 1, 4);
                    4'd4: t = mk_tap(0, 1, 5);
                    4'd5: t = mk_tap(1, 1, 4);
                    4'd6: t = mk_tap(2, 1, 2);
                    4'd7: t = mk_tap(-1, 2, 2);
                    4'd8: t = mk_tap(0, 2, 3);
                    4'd9: t = mk_tap(1, 2, 2);
                    default: t = mk_tap(0, 0, 0);
                endcase
            end
            MODE_ATKINSON: begin
                case (idx)
                    4'd0: t = mk_tap(1, 0, 1);
                    4'd1: t = mk_tap(2, 0, 1);
                    4'd2: t = mk_tap(-1, 1, 1);
                    4'd3: t = mk_tap(0, 1, 1);
                    4'd4: t = mk_tap(1, 1, 1);
                    4'd5: t = mk_tap(0, 2, 1);
                    default: t = mk_tap(0, 0, 0);
                endcase
            end
            default: t = mk_tap(0, 0, 0);
        endcase
        return t;
    endfunction

    function automatic logic [3:0] ntaps_of(input logic [2:0] mode);
        case (mode)
            MODE_FLOYD:    return 4'd4;
            MODE_JJN:      return 4'd12;
            MODE_SIERRA:   return 4'd10;
            MODE_ATKINSON: return 4'd6;
            default:       return 4'd0;
        endcase
    endfunction

    function automatic logic [5:0] kdiv_of(input logic [2:0] mode);
        case (mode)
            MODE_FLOYD:    return 6'd16;
            MODE_JJN:      return 6'd48;
            MODE_SIERRA:   return 6'd32;
            MODE_ATKINSON: return 6'd8;
            default:       return 6'd1;
        endcase
    endfunction

    function automatic logic is_diffusion(input logic [2:0] mode);
        return (mode == MODE_FLOYD) || (mode == MODE_JJN) ||
               (mode == MODE_SIERRA) || (mode == MODE_ATKINSON);
    endfunction

endpackage
`default_nettype wire

// File: design/multi_mode_dither_quantizer_unit.sv
// Multi-mode dither quantizer: grey Q.16 pixels in raster order in, one level per pixel out.
// Pixel channel: i_pixel_valid / o_pixel_ready / i_pixel_in. Result channel:
// o_level_valid / i_level_ready with o_level_out, o_end_of_row, o_end_of_frame.
// Registers (APB, byte address 4*i): quant_bits, dither_mode, image_width,
// image_height; write them only while no item is in flight.
// One item is worked on at a time, the error row store being read and written back
// through its one read port and one write port. In the rounding and ordered modes an
// item passes from accept through the states RD, CALC and MUL to OUT, and a new item
// can be taken in the cycle after the previous one leaves for the output register,
// not before. The diffusion modes add the reconstruction divide in a bit-serial divider
// of NW = ERROR_FRAC_BITS+9 bits, then, for every tap that lies inside the image, the
// states TDIV, TRD and TWR; a tap outside the image only steps the tap index in TAP.
// The first pixel of every frame first sweeps the three error rows to zero,
// all 3*MAX_WIDTH cells. Reset clears the position to the frame start, the output
// valid, and loads the register defaults; the error store is cleared by that sweep.
// When the receiver stalls, the finished result holds in the output register; the
// next item may be accepted and worked on, and its result waits for that register.
`timescale 1ns / 1ps
`default_nettype none
module multi_mode_dither_quantizer_unit #(
    parameter int MAX_WIDTH       = dmq_pkg::DEF_MAX_WIDTH,
    parameter int ERROR_FRAC_BITS = dmq_pkg::DEF_ERROR_FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_pixel_valid,
    output logic             o_pixel_ready,
    input  wire logic [16:0] i_pixel_in,
    output logic             o_level_valid,
    input  wire logic        i_level_ready,
    output logic [7:0]       o_level_out,
    output logic             o_end_of_row,
    output logic             o_end_of_frame
);
    import dmq_pkg::*;

    localparam int F     = ERROR_FRAC_BITS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
    localparam int XW    = WW + 2;
    localparam int DEPTH = 3 * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = F + 9;
    localparam int VW    = 34;
    localparam int SW    = ((NW > 32) ? NW : 32) + 1;
    localparam int PW    = F + 9;
    // reciprocal of 3, exact for magnitudes below 2^(F-1)
    localparam logic [F-1:0] RECIP3 = F'(((64'd1 << F) + 64'd2) / 64'd3);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_CALC = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_QV   = 4'd5;
    localparam logic [3:0] S_QVW  = 4'd6;
    localparam logic [3:0] S_TAP  = 4'd7;
    localparam logic [3:0] S_TDIV = 4'd8;
    localparam logic [3:0] S_TRD  = 4'd9;
    localparam logic [3:0] S_TWR  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    // configuration
    logic [3:0]  r_quant_bits;
    logic [2:0]  r_dither_mode;
    logic [10:0] r_image_width;
    logic [15:0] r_image_height;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quant_bits   <= RST_QUANT_BITS;
            r_dither_mode  <= RST_DITHER_MODE;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_QUANT_BITS:   r_quant_bits   <= pwdata[3:0];
                REG_DITHER_MODE:  r_dither_mode  <= pwdata[2:0];
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_QUANT_BITS:   prdata = {28'd0, r_quant_bits};
            REG_DITHER_MODE:  prdata = {29'd0, r_dither_mode};
            REG_IMAGE_WIDTH:  prdata = {21'd0, r_image_width};
            REG_IMAGE_HEIGHT: prdata = {16'd0, r_image_height};
            default:          prdata = 32'd0;
        endcase
    end

    // effective configuration
    logic [3:0]    bits_eff;
    logic [WW-1:0] width_eff;
    logic [15:0]   height_eff;
    logic [8:0]    levels_p1;

    always_comb begin
        if (r_quant_bits == 4'd0) begin
            bits_eff = 4'd1;
        end else if (r_quant_bits > 4'd8) begin
            bits_eff = 4'd8;
        end else begin
            bits_eff = r_quant_bits;
        end
        if (r_image_width == 11'd0) begin
            width_eff = WW'(1);
        end else if (WW'(r_image_width) > WW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_image_width);
        end
        height_eff = (r_image_height == 16'd0) ? 16'd1 : r_image_height;
        levels_p1  = 9'd1 << bits_eff;
    end

    // position
    logic [CW-1:0] r_col_cnt;
    logic [15:0]   r_row_cnt;
    logic [1:0]    r_row_slot;
    logic          accept;
    logic          eor_now;
    logic          eof_now;

    assign accept  = i_pixel_valid && o_pixel_ready;
    assign eor_now = WW'(r_col_cnt) >= (width_eff - WW'(1));
    assign eof_now = eor_now && (r_row_cnt >= (height_eff - 16'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_row_slot <= 2'd0;
        end else if (accept) begin
            if (eor_now) begin
                r_col_cnt <= '0;
                if (eof_now) begin
                    r_row_cnt  <= '0;
                    r_row_slot <= 2'd0;
                end else begin
                    r_row_cnt  <= r_row_cnt + 16'd1;
                    r_row_slot <= (r_row_slot == 2'd2) ? 2'd0 : r_row_slot + 2'd1;
                end
            end else begin
                r_col_cnt <= r_col_cnt + 1'b1;
            end
        end
    end

    // item registers
    logic [3:0]          r_state;
    logic [16:0]         r_pix;
    logic [CW-1:0]       r_col;
    logic [15:0]         r_row;
    logic [1:0]          r_slot;
    logic                r_eor;
    logic                r_eof;
    logic [2:0]          r_mode;
    logic [7:0]          r_lmax;
    logic [WW-1:0]       r_weff;
    logic [15:0]         r_heff;
    logic [F:0]          r_v;
    logic [7:0]          r_level;
    logic signed [F+1:0] r_e;
    logic [3:0]          r_tap;
    logic signed [NW-1:0] r_tq;
    logic signed [NW-1:0] r_c;
    logic [AW-1:0]       r_clr;

    logic                r_ovalid;
    logic [7:0]          r_olevel;
    logic                r_oeor;
    logic                r_oeof;

    // error store and divider
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [31:0]          mem_wdata;
    logic [AW-1:0]        mem_raddr;
    logic [31:0]          mem_rdata;
    logic                 div_start;
    logic signed [NW-1:0] div_num;
    logic [7:0]           div_den;
    logic                 div_done;
    logic signed [NW-1:0] div_quot;

    dmq_err_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dmq_div #(
        .NW (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    function automatic logic [AW-1:0] cell_addr(input logic [1:0] slot, input logic [CW-1:0] x);
        logic [AW-1:0] base;
        case (slot)
            2'd1:    base = AW'(MAX_WIDTH);
            2'd2:    base = AW'(2 * MAX_WIDTH);
            default: base = '0;
        endcase
        return base + AW'(x);
    endfunction

    // tap geometry
    t_tap            tap;
    logic [3:0]      ntaps;
    logic [5:0]      kdiv;
    logic [XW-1:0]   tap_x;
    logic [16:0]     tap_y;
    logic [2:0]      tap_slot_raw;
    logic [1:0]      tap_slot;
    logic            tap_in;
    logic [AW-1:0]   tap_addr;
    logic [AW-1:0]   own_addr;
    logic signed [NW-1:0] ew;

    assign tap          = tap_of(r_mode, r_tap);
    assign ntaps        = ntaps_of(r_mode);
    assign kdiv         = kdiv_of(r_mode);
    assign tap_x        = XW'(r_col) + XW'(tap.dx);
    assign tap_y        = {1'b0, r_row} + 17'(tap.dy);
    assign tap_slot_raw = 3'(r_slot) + 3'(tap.dy);
    assign tap_slot     = (tap_slot_raw >= 3'd3) ? 2'(tap_slot_raw - 3'd3) : tap_slot_raw[1:0];
    assign tap_in       = !tap_x[XW-1] && (tap_x[XW-2:0] < (XW-1)'(r_weff)) &&
                          (tap_y < {1'b0, r_heff});
    assign tap_addr     = cell_addr(tap_slot, tap_x[CW-1:0]);
    assign own_addr     = cell_addr(r_slot, r_col);
    assign ew           = NW'(r_e) * $signed(NW'({1'b0, tap.w}));

    // tap share: the weighted error plus half the divisor, floor-divided by the kernel
    // divisor: a shift and for /48 a reciprocal multiply by 3 in the following cycle
    logic signed [NW-1:0] tap_num;
    logic signed [NW-1:0] tap_shr;
    logic                 t_neg;
    logic [F-1:0]         t_mag;
    logic [2*F-1:0]       t_prod;
    logic [F-1:0]         t_q3;
    logic signed [NW-1:0] t_c;

    always_comb begin
        tap_num = ew + NW'(kdiv >> 1);
        case (r_mode)
            MODE_SIERRA:   tap_shr = tap_num >>> 5;
            MODE_ATKINSON: tap_shr = tap_num >>> 3;
            default:       tap_shr = tap_num >>> 4;
        endcase
    end

    assign t_neg  = r_tq[NW-1];
    assign t_mag  = t_neg ? F'(NW'(2) - r_tq) : F'(r_tq);
    assign t_prod = (2*F)'(t_mag) * (2*F)'(RECIP3);
    assign t_q3   = t_prod[2*F-1:F];
    assign t_c    = t_neg ? -$signed(NW'(t_q3)) : $signed(NW'(t_q3));

    // working value
    logic signed [VW-1:0] v_base;
    logic signed [VW-1:0] v_add;
    logic signed [VW-1:0] v_sum;
    logic [F:0]           v_clamp;
    logic [5:0]           bayer_m;
    logic [4:0]           half_m;
    logic [PW-1:0]        prod;
    logic [PW-1:0]        level_full;
    logic signed [SW-1:0] acc_sum;
    logic [31:0]          acc_sat;

    assign bayer_m = BAYER8[{r_row[2:0], r_col[2:0]}];
    assign half_m  = HALF4[{r_row[1:0], r_col[1:0]}];
    assign v_base  = VW'({r_pix, (F-16)'(0)});

    always_comb begin
        case (r_mode)
            MODE_BAYER8: v_add = VW'({bayer_m, (F-6)'(0)}) - VW'(1 << (F - 1));
            MODE_HALF4:  v_add = VW'({half_m, (F-4)'(0)}) - VW'(1 << (F - 1));
            MODE_FLOYD, MODE_JJN, MODE_SIERRA, MODE_ATKINSON:
                v_add = VW'($signed(mem_rdata));
            default:     v_add = '0;
        endcase
        v_sum = v_base + v_add;
        if (v_sum < 0) begin
            v_clamp = '0;
        end else if (v_sum > VW'(1 << F)) begin
            v_clamp = (F+1)'(1 << F);
        end else begin
            v_clamp = v_sum[F:0];
        end
    end

    assign prod       = PW'(r_v) * PW'(r_lmax);
    assign level_full = (prod + PW'(1 << (F - 1))) >> F;

    always_comb begin
        acc_sum = SW'($signed(mem_rdata)) + SW'(r_c);
        if (acc_sum > SW'(32'sh7fffffff)) begin
            acc_sat = 32'h7fffffff;
        end else if (acc_sum < -SW'(33'sh80000000)) begin
            acc_sat = 32'h80000000;
        end else begin
            acc_sat = acc_sum[31:0];
        end
    end

    // memory and divider controls
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = own_addr;
        mem_wdata = 32'd0;
        mem_raddr = own_addr;
        div_start = 1'b0;
        div_num   = NW'({r_level, F'(0)}) + NW'(r_lmax >> 1);
        div_den   = r_lmax;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
            end
            S_CALC: begin
                mem_we = 1'b1;
            end
            S_QV: begin
                div_start = 1'b1;
            end
            S_TRD: begin
                mem_raddr = tap_addr;
            end
            S_TWR: begin
                mem_we    = 1'b1;
                mem_waddr = tap_addr;
                mem_wdata = acc_sat;
            end
            default: ;
        endcase
    end

    assign o_pixel_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_clr   <= '0;
            r_tap   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_clr   <= '0;
                        r_state <= (r_col_cnt == '0 && r_row_cnt == 16'd0) ? S_CLR : S_RD;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_RD;
                    end
                end
                S_RD:   r_state <= S_CALC;
                S_CALC: r_state <= S_MUL;
                S_MUL:  r_state <= is_diffusion(r_mode) ? S_QV : S_OUT;
                S_QV:   r_state <= S_QVW;
                S_QVW: begin
                    if (div_done) begin
                        r_tap   <= '0;
                        r_state <= S_TAP;
                    end
                end
                S_TAP: begin
                    if (r_tap == ntaps) begin
                        r_state <= S_OUT;
                    end else if (tap_in) begin
                        r_state <= S_TDIV;
                    end else begin
                        r_tap <= r_tap + 4'd1;
                    end
                end
                S_TDIV: r_state <= S_TRD;
                S_TRD:  r_state <= S_TWR;
                S_TWR: begin
                    r_tap   <= r_tap + 4'd1;
                    r_state <= S_TAP;
                end
                S_OUT: begin
                    if (!r_ovalid || i_level_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix  <= i_pixel_in;
            r_col  <= r_col_cnt;
            r_row  <= r_row_cnt;
            r_slot <= r_row_slot;
            r_eor  <= eor_now;
            r_eof  <= eof_now;
            r_mode <= r_dither_mode;
            r_lmax <= 8'(levels_p1 - 9'd1);
            r_weff <= width_eff;
            r_heff <= height_eff;
        end
        if (r_state == S_CALC) begin
            r_v <= v_clamp;
        end
        if (r_state == S_MUL) begin
            r_level <= level_full[7:0];
        end
        if (r_state == S_QVW && div_done) begin
            r_e <= $signed({1'b0, r_v}) - (F+2)'(div_quot);
        end
        if (r_state == S_TAP) begin
            r_tq <= tap_shr;
        end
        if (r_state == S_TDIV) begin
            r_c <= (r_mode == MODE_JJN) ? t_c : r_tq;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && (!r_ovalid || i_level_ready)) begin
            r_ovalid <= 1'b1;
        end else if (i_level_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || i_level_ready)) begin
            r_olevel <= r_level;
            r_oeor   <= r_eor;
            r_oeof   <= r_eof;
        end
    end

    assign o_level_valid  = r_ovalid;
    assign o_level_out    = r_olevel;
    assign o_end_of_row   = r_oeor;
    assign o_end_of_frame = r_oeof;

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("error store written while idle");

    a_mid_frame_skips_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (r_col_cnt != '0 || r_row_cnt != 16'd0)) |=> (r_state == S_RD))
        else $error("clearing pass started inside a frame");

    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP) |-> (r_tap <= ntaps))
        else $error("tap index past kernel size");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_slot != 2'd3)
        else $error("row slot out of rotation");

    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_QVW))
        else $error("divider finished outside a wait state");
`endif
endmodule
`default_nettype wire

// File: design/dmq_err_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module dmq_err_mem #(
    parameter int DEPTH = 3072,
    parameter int AW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);
    logic [31:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/dmq_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Floor division of a signed numerator by an 8-bit divisor, one quotient bit a cycle.
module dmq_div #(
    parameter int NW = 33
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic [7:0]           i_den,
    output logic                      o_done,
    output logic signed [NW-1:0]      o_quot
);
    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic            r_neg;
    logic [NW-1:0]   r_q;
    logic [7:0]      r_rem;
    logic [7:0]      r_den;
    logic [8:0]      trial;
    logic            fits;
    logic [NW-1:0]   mag;

    assign trial = {r_rem, r_q[NW-1]};
    assign fits  = trial >= {1'b0, r_den};
    assign mag   = r_q + NW'(r_neg && (r_rem != 8'd0));
    assign o_quot = r_neg ? -$signed(mag) : $signed(mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NW-1];
            r_q   <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_rem <= 8'd0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? 8'(trial - {1'b0, r_den}) : trial[7:0];
            r_q   <= {r_q[NW-2:0], fits};
        end
    end
endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import dmq_pkg::*;

    localparam int MAXW = DEF_MAX_WIDTH;
    localparam int FB   = DEF_ERROR_FRAC_BITS;

    // Item seen on the result channel
    typedef struct {
        logic [7:0] level;
        logic       eor;
        logic       eof;
    } t_level;

    // Dither predictor and queue of pending levels
    class level_board;
        logic [3:0]  qbits;
        logic [2:0]  mode;
        logic [10:0] width;
        logic [15:0] height;
        int unsigned col, row;
        int          err_rows [3][MAXW];
        t_level      pending [$];
        int          errors;

        function void reset_state();
            qbits = RST_QUANT_BITS;
            mode = RST_DITHER_MODE;
            width = RST_IMAGE_WIDTH;
            height = RST_IMAGE_HEIGHT;
            col = 0;
            row = 0;
            errors = 0;
            foreach (err_rows[i, j]) err_rows[i][j] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_QUANT_BITS:   qbits = val[3:0];
                REG_DITHER_MODE:  mode = val[2:0];
                REG_IMAGE_WIDTH:  width = val[10:0];
                REG_IMAGE_HEIGHT: height = val[15:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [16:0] pix);
            longint one, half, lv, v, herr, lvl, qv, e, c, num;
            int unsigned bits, w, h, c0, slot, y, n, dv;
            int x;
            t_tap tp;
            t_level r;
            one = longint'(1) << FB;
            half = longint'(1) << (FB - 1);
            bits = (qbits < 1) ? 1 : (qbits > 8 ? 8 : qbits);
            w = (width < 1) ? 1 : (width > MAXW ? MAXW : width);
            h = (height < 1) ? 1 : height;
            c0 = col % MAXW;
            slot = row % 3;
            lv = (longint'(1) << bits) - 1;
            v = longint'(pix) << (FB - 16);
            if (c0 == 0 && row == 0) foreach (err_rows[i, j]) err_rows[i][j] = 0;
            herr = err_rows[slot][c0];
            err_rows[slot][c0] = 0;
            n = ntaps_of(mode);
            dv = kdiv_of(mode);
            if (mode == MODE_BAYER8)
                v += (longint'(BAYER8[(row % 8) * 8 + c0 % 8]) << (FB - 6)) - half;
            else if (mode == MODE_HALF4)
                v += (longint'(HALF4[(row % 4) * 4 + c0 % 4]) << (FB - 4)) - half;
            else if (n != 0)
                v += herr;
            if (v < 0) v = 0;
            if (v > one) v = one;
            lvl = (v * lv + half) >>> FB;
            if (n != 0) begin
                qv = ((lvl << FB) + lv / 2) / lv;
                e = v - qv;
                for (int i = 0; i < n; i++) begin
                    tp = tap_of(mode, 4'(i));
                    x = int'(c0) + int'(tp.dx);
                    y = row + tp.dy;
                    if (x < 0 || x >= int'(w) || y >= h) continue;
                    num = e * tp.w + dv / 2;
                    c = (num >= 0) ? num / dv : -((-num + dv - 1) / dv);
                    c = c + err_rows[y % 3][x];
                    if (c > 64'sh7fffffff) c = 64'sh7fffffff;
                    if (c < -64'sh80000000) c = -64'sh80000000;
                    err_rows[y % 3][x] = int'(c);
                end
            end
            r.level = lvl[7:0];
            r.eor = (col >= w - 1);
            r.eof = r.eor && (row >= h - 1);
            if (r.eor) begin
                col = 0;
                row = r.eof ? 0 : ((row + 1) & 16'hffff);
            end else begin
                col++;
            end
            pending.push_back(r);
        endfunction

        function void check_level(t_level got);
            t_level exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected level %0d", $time, got.level);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.level !== exp_r.level || got.eor !== exp_r.eor
                    || got.eof !== exp_r.eof) begin
                $display("%0t: mismatch exp lvl=%0d eor=%0b eof=%0b got lvl=%0d eor=%0b eof=%0b",
                         $time, exp_r.level, exp_r.eor, exp_r.eof,
                         got.level, got.eor, got.eof);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_pixel_valid = 1'b0;
    logic        o_pixel_ready;
    logic [16:0] i_pixel_in = '0;
    logic        o_level_valid;
    logic        i_level_ready = 1'b0;
    logic [7:0]  o_level_out;
    logic        o_end_of_row, o_end_of_frame;
    logic        stall_on = 1'b1;
    level_board  board;

    multi_mode_dither_quantizer_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Receiver: check on handshake, stall at random while stall_on is set
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_level_valid && i_level_ready)
                board.check_level('{o_level_out, o_end_of_row, o_end_of_frame});
            i_level_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.write_reg(idx, val);
    endtask

    // Valid stays high after an accept; the next item, a gap or a drain takes it over
    task automatic send_pixel(logic [16:0] pix);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_pixel_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (!o_pixel_ready);
        board.note_pixel(pix);
    endtask

    task automatic drain();
        i_pixel_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_all(int qb, int md, int wd, int ht);
        drain();
        write_reg(REG_QUANT_BITS, qb);
        write_reg(REG_DITHER_MODE, md);
        write_reg(REG_IMAGE_WIDTH, wd);
        write_reg(REG_IMAGE_HEIGHT, ht);
    endtask

    function automatic logic [16:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1ffff - $urandom_range(0, 65535);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    initial begin
        int wd, ht;
        board = new();
        board.reset_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: defaults, extremes, every mode
        send_pixel(17'd0);
        send_pixel(17'd65536);
        set_all(8, MODE_ROUND, 3, 2);
        send_pixel(17'd32768);
        send_pixel(17'h1ffff);
        send_pixel(17'd128);
        send_pixel(17'd65535);
        send_pixel(17'd1);
        send_pixel(17'd98304);
        for (int md = 1; md < 8; md++) begin
            set_all((md == 7) ? 0 : md, md, 2, 2);
            for (int k = 0; k < 4; k++) send_pixel(rand_pixel());
        end
        // out-of-range width, height and depth
        set_all(15, MODE_FLOYD, 0, 0);
        send_pixel(17'd40000);
        send_pixel(17'd20000);
        set_all(4, MODE_ATKINSON, 2047, 2);
        send_pixel(17'd12345);

        // random frames
        for (int ph = 0; ph < 24; ph++) begin
            wd = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
            ht = $urandom_range(1, 5);
            if (ph == 5) begin wd = 1; ht = 1; end
            if (ph == 10) wd = MAXW;
            if (ph == 10) ht = 1;
            stall_on = (ph % 4 != 3);
            set_all($urandom_range(0, 15), $urandom_range(0, 7), wd, ht);
            for (int k = 0; k < ((ph == 10) ? 30 : $urandom_range(12, 30)); k++) begin
                send_pixel(rand_pixel());
                if (ph == 7 && k == 6) begin
                    drain();
                end
            end
        end
        stall_on = 1'b1;
        drain();
        if (board.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb: errors");
        $finish;
    end
endmodule

// File: multi_mode_dither_quantizer_unit.f
design/dmq_pkg.sv
design/dmq_err_mem.sv
design/dmq_div.sv
design/multi_mode_dither_quantizer_unit.sv
sim/tb.sv
